[sv/h264aus_pkg.sv]
// Package for the H.264 access unit splitter: NAL type codes, queue sizing,
// and the result record and push bundle shared by the parser and the queue.
// No dependencies.
package h264aus_pkg;

    localparam int POS_BITS_DEF = 32;
    localparam int OUT_BITS     = 32;

    localparam logic [4:0] NAL_TYPE_MASK = 5'h1F;
    localparam int         FIRST_MB_BIT  = 7;

    localparam logic [4:0] NAL_SLICE = 5'd1;
    localparam logic [4:0] NAL_IDR   = 5'd5;
    localparam logic [4:0] NAL_SEI   = 5'd6;
    localparam logic [4:0] NAL_SPS   = 5'd7;
    localparam logic [4:0] NAL_PPS   = 5'd8;
    localparam logic [4:0] NAL_AUD   = 5'd9;

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);
    localparam int QCNT   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [OUT_BITS-1:0] offset;
        logic [OUT_BITS-1:0] length;
        logic                key;
        logic                last;
    } t_rec;

    // Results of one byte: cnt records, the earlier one always in rec0.
    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

[sv/h264aus_parse.sv]
// Start code scanner and frame boundary tracker of the access unit splitter.
// Produces up to two frame records per accepted byte. Depends on h264aus_pkg.
module h264aus_parse
    import h264aus_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_eos,
    output t_push       o_push
);

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_HEADER,
        PH_SLICE_BYTE
    } t_phase;

    localparam int EXT_BITS = POSITION_BITS + OUT_BITS;

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_zero_run, n_zero_run;
    logic [4:0]               r_pend_type, n_pend_type;
    logic [POSITION_BITS-1:0] r_code_pos, n_code_pos;
    logic [POSITION_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [POSITION_BITS-1:0] r_frame_start, n_frame_start;
    logic                     r_open, n_open;
    logic                     r_has_slice, n_has_slice;
    logic                     r_has_idr, n_has_idr;

    logic                     take_v;
    logic [4:0]               take_t;
    logic                     take_fm;
    logic                     is_slice, is_delim;
    logic [4:0]               hdr_type;
    logic                     close_v;
    logic [POSITION_BITS-1:0] close_len, eos_len;
    t_rec                     close_rec, eos_rec;

    function automatic logic [OUT_BITS-1:0] to_out(input logic [POSITION_BITS-1:0] v);
        logic [EXT_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, v};
        return ext[OUT_BITS-1:0];
    endfunction

    assign hdr_type = i_data_byte[4:0] & NAL_TYPE_MASK;
    assign is_slice = (take_t == NAL_SLICE) || (take_t == NAL_IDR);
    assign is_delim = (take_t == NAL_SEI) || (take_t == NAL_SPS) ||
                      (take_t == NAL_PPS) || (take_t == NAL_AUD);

    always_comb begin
        n_phase       = PH_SCAN;
        n_zero_run    = r_zero_run;
        n_pend_type   = r_pend_type;
        n_code_pos    = r_code_pos;
        n_byte_pos    = r_byte_pos;
        n_frame_start = r_frame_start;
        n_open        = r_open;
        n_has_slice   = r_has_slice;
        n_has_idr     = r_has_idr;
        take_v        = 1'b0;
        take_t        = hdr_type;
        take_fm       = 1'b0;
        close_v       = 1'b0;

        unique case (r_phase)
            PH_HEADER: begin
                if (hdr_type == NAL_SLICE || hdr_type == NAL_IDR) begin
                    n_pend_type = hdr_type;
                    n_phase     = PH_SLICE_BYTE;
                end else begin
                    take_v = 1'b1;
                end
            end
            PH_SLICE_BYTE: begin
                take_v  = 1'b1;
                take_t  = r_pend_type;
                take_fm = i_data_byte[FIRST_MB_BIT];
            end
            default: n_phase = PH_SCAN;
        endcase

        // A NAL whose type is known opens, closes or joins a frame, or is ignored if it cannot open one.
        if (take_v) begin
            if (!r_open) begin
                if (is_slice || take_t == NAL_SPS || take_t == NAL_PPS) begin
                    n_open        = 1'b1;
                    n_frame_start = r_code_pos;
                    n_has_slice   = is_slice;
                    n_has_idr     = (take_t == NAL_IDR);
                end
            end else if (r_has_slice && (is_delim || (is_slice && take_fm))) begin
                close_v       = 1'b1;
                n_frame_start = r_code_pos;
                n_has_slice   = is_slice;
                n_has_idr     = (take_t == NAL_IDR);
            end else begin
                n_has_slice = r_has_slice | is_slice;
                n_has_idr   = r_has_idr | (take_t == NAL_IDR);
            end
        end

        if (i_data_byte == 8'd1 && r_zero_run == 2'd2) begin
            n_code_pos = r_byte_pos - POSITION_BITS'(2);
            n_phase    = PH_HEADER;
            n_zero_run = 2'd0;
        end else if (i_data_byte == 8'd0) begin
            if (r_zero_run != 2'd2) begin
                n_zero_run = r_zero_run + 2'd1;
            end
        end else begin
            n_zero_run = 2'd0;
        end

        close_len = r_code_pos - r_frame_start;
        eos_len   = r_byte_pos + POSITION_BITS'(1) - n_frame_start;

        close_rec.offset = to_out(r_frame_start);
        close_rec.length = to_out(close_len);
        close_rec.key    = r_has_idr;
        close_rec.last   = 1'b0;

        eos_rec.offset = to_out(n_frame_start);
        eos_rec.length = to_out(eos_len);
        eos_rec.key    = n_has_idr;
        eos_rec.last   = 1'b1;

        o_push.cnt  = 2'd0;
        o_push.rec0 = close_rec;
        o_push.rec1 = eos_rec;
        if (i_accept) begin
            if (close_v && i_eos && n_open) begin
                o_push.cnt = 2'd2;
            end else if (close_v) begin
                o_push.cnt = 2'd1;
            end else if (i_eos && n_open) begin
                o_push.cnt  = 2'd1;
                o_push.rec0 = eos_rec;
            end
        end

        // End of stream returns everything to the reset state.
        if (i_eos) begin
            n_phase       = PH_SCAN;
            n_zero_run    = 2'd0;
            n_pend_type   = '0;
            n_code_pos    = '0;
            n_byte_pos    = '0;
            n_frame_start = '0;
            n_open        = 1'b0;
            n_has_slice   = 1'b0;
            n_has_idr     = 1'b0;
        end else begin
            n_byte_pos = r_byte_pos + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SCAN;
            r_zero_run    <= 2'd0;
            r_pend_type   <= '0;
            r_code_pos    <= '0;
            r_byte_pos    <= '0;
            r_frame_start <= '0;
            r_open        <= 1'b0;
            r_has_slice   <= 1'b0;
            r_has_idr     <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_zero_run    <= n_zero_run;
            r_pend_type   <= n_pend_type;
            r_code_pos    <= n_code_pos;
            r_byte_pos    <= n_byte_pos;
            r_frame_start <= n_frame_start;
            r_open        <= n_open;
            r_has_slice   <= n_has_slice;
            r_has_idr     <= n_has_idr;
        end
    end

`ifndef SYNTH
    a_eos_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eos) |=> (r_byte_pos == '0 && !r_open))
        else $error("byte position or frame state survived end of stream");

    a_two_results_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |-> (o_push.rec1.last && !o_push.rec0.last))
        else $error("two results per byte out of order");

    a_idr_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_has_idr |-> (r_has_slice && r_open))
        else $error("keyframe mark without an open frame holding a slice");
`endif

endmodule

[sv/h264aus_outq.sv]
// Result queue of the access unit splitter: takes up to two frame records per
// cycle and hands out one per output transaction. Depends on h264aus_pkg.
module h264aus_outq
    import h264aus_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_rec   o_rec
);

    t_rec             r_mem [QDEPTH];
    logic [QPTR-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT-1:0]  r_count, n_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= QCNT'(QDEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign o_rec   = r_mem[r_rd_ptr];
    assign n_count = r_count + QCNT'(i_push.cnt) - QCNT'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr_ptr + QPTR'(1)] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR'(i_push.cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT'(QDEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("records pushed while the queue lacked room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.cnt == 2'd0) |=> (r_count == $past(r_count) - QCNT'(1)))
        else $error("queue count did not drop on a lone pop");
`endif

endmodule

[sv/h264_access_unit_splitter_core.sv]
// A frame record enters the result queue when its closing byte is accepted and leaves it on the master side.
// Throughput: one byte per cycle while the queue has room; a byte ending the stream may close
// two frames; their records leave one by one from a four-entry queue that stalls input at three.
// Reset (synchronous, active low) clears the scanner, frame state and queue.
// Top level of the access unit splitter; depends on h264aus_pkg, h264aus_parse, h264aus_outq.
module h264_access_unit_splitter_core
    import h264aus_pkg::*;
#(
    parameter int POSITION_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] frame_offset, [63:32] frame_length
    output logic        m_axis_tuser,   // [0] keyframe_flag
    output logic        m_axis_tlast    // last_frame
);

    logic  accept;
    logic  room;
    t_push push;
    t_rec  head;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    h264aus_parse #(
        .POSITION_BITS(POSITION_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_eos       (s_axis_tlast),
        .o_push      (push)
    );

    h264aus_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (head)
    );

    assign m_axis_tdata = {head.length, head.offset};
    assign m_axis_tuser = head.key;
    assign m_axis_tlast = head.last;

endmodule
